FILE: hw/rtl/rlc_pkg.sv
// rlc_pkg: widths, coefficients, config codes and the counts-per-lux table
// for the RGBC lux calculator. No dependencies; imported by every rlc module.
`default_nettype none

package rlc_pkg;

  // field and datapath widths
  localparam int IN_W   = 16;  // raw channel count
  localparam int SEL_W  = 2;   // config select codes
  localparam int COL_W  = 18;  // IR-corrected colour, signed
  localparam int SUM_W  = 29;  // weighted sum, signed
  localparam int DVD_W  = 28;  // positive weighted sum, unsigned dividend
  localparam int CPL_W  = 18;  // counts per lux
  localparam int REM_W  = CPL_W;
  localparam int LUX_W  = 21;
  localparam int CFG_IDX_W = 2;

  localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

  // colour weights
  localparam logic signed [SUM_W-1:0] COEF_RED   = -29'sd97;
  localparam logic signed [SUM_W-1:0] COEF_GREEN = 29'sd1000;
  localparam logic signed [SUM_W-1:0] COEF_BLUE  = -29'sd482;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ITIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN  = 2'd1;

  // reset codes: 12 ms, 1x
  localparam logic [SEL_W-1:0] ITIME_RST = 2'd0;
  localparam logic [SEL_W-1:0] GAIN_RST  = 2'd0;

  // (itime_ms * 1000 * gain) / 127, indexed {itime, gain};
  // the unused itime code repeats the 400 ms row
  localparam logic [CPL_W-1:0] CPL_TABLE [16] = '{
    18'd94,     18'd377,    18'd1511,   18'd6047,
    18'd787,    18'd3149,   18'd12598,  18'd50393,
    18'd3149,   18'd12598,  18'd50393,  18'd201574,
    18'd3149,   18'd12598,  18'd50393,  18'd201574
  };

  // one beat moving down the divider row
  typedef struct packed {
    logic [REM_W-1:0] rem;  // partial remainder
    logic [DVD_W-1:0] dq;   // dividend bits left, quotient bits shifted in
  } rlc_div_t;

  function automatic logic [CPL_W-1:0] rlc_cpl(input logic [SEL_W-1:0] itime,
                                              input logic [SEL_W-1:0] gain);
    return CPL_TABLE[{itime, gain}];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rlc_front.sv
// rlc_front: IR removal, weighting and clamp, three registered stages.
// Depends on rlc_pkg; feeds the divider row.
`default_nettype none

module rlc_front
  import rlc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output      logic             up_stall,
  input  wire logic [IN_W-1:0]  red_count,
  input  wire logic [IN_W-1:0]  green_count,
  input  wire logic [IN_W-1:0]  blue_count,
  input  wire logic [IN_W-1:0]  clear_count,
  output      logic             dn_valid,
  output      logic [DVD_W-1:0] dn_dividend,
  input  wire logic             dn_stall
);

  logic                    va_r, vb_r, vc_r;
  logic                    hold_a, hold_b, hold_c;
  logic [IN_W+1:0]         rgb_sum;
  logic signed [IN_W+2:0]  diff;
  logic signed [COL_W-1:0] ir;
  logic signed [COL_W-1:0] rp_r, gp_r, bp_r;
  logic signed [COL_W-1:0] rp_nxt, gp_nxt, bp_nxt;
  logic signed [SUM_W-1:0] pr_r, pg_r, pb_r;
  logic signed [SUM_W-1:0] wsum;
  logic [DVD_W-1:0]        dvd_r, dvd_nxt;

  // a stage holds when it is full and the next one holds
  assign hold_c   = vc_r & dn_stall;
  assign hold_b   = vb_r & hold_c;
  assign hold_a   = va_r & hold_b;
  assign up_stall = hold_a;

  // stage A: IR = floor((R+G+B-C)/2), removed from each colour
  always_comb begin
    rgb_sum = {2'b00, red_count} + {2'b00, green_count} + {2'b00, blue_count};
    diff    = $signed({1'b0, rgb_sum}) - $signed({3'b000, clear_count});
    ir      = diff[IN_W+2:1];
    rp_nxt  = $signed({2'b00, red_count})   - ir;
    gp_nxt  = $signed({2'b00, green_count}) - ir;
    bp_nxt  = $signed({2'b00, blue_count})  - ir;
  end

  // stage C input: weighted sum, negative or zero clamps to zero
  always_comb begin
    wsum    = pr_r + pg_r + pb_r;
    dvd_nxt = (wsum > 0) ? wsum[DVD_W-1:0] : '0;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (!hold_a) va_r <= up_valid;
      if (!hold_b) vb_r <= va_r;
      if (!hold_c) vc_r <= vb_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!hold_a) begin
      rp_r <= rp_nxt;
      gp_r <= gp_nxt;
      bp_r <= bp_nxt;
    end
    // stage B: one constant product per colour
    if (!hold_b) begin
      pr_r <= SUM_W'(rp_r) * COEF_RED;
      pg_r <= SUM_W'(gp_r) * COEF_GREEN;
      pb_r <= SUM_W'(bp_r) * COEF_BLUE;
    end
    if (!hold_c) dvd_r <= dvd_nxt;
  end

  assign dn_valid    = vc_r;
  assign dn_dividend = dvd_r;

endmodule

`default_nettype wire

FILE: hw/rtl/rlc_div_cell.sv
// rlc_div_cell: one restoring-division cell, resolves one quotient bit.
// Depends on rlc_pkg (rlc_div_t); chained DVD_W deep in the top level.
`default_nettype none

module rlc_div_cell
  import rlc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CPL_W-1:0] divisor,
  input  wire logic             up_valid,
  input  wire rlc_div_t         up_data,
  output      logic             up_stall,
  output      logic             dn_valid,
  output      rlc_div_t         dn_data,
  input  wire logic             dn_stall
);

  logic             valid_r;
  rlc_div_t         data_r, data_nxt;
  logic             hold;
  logic [REM_W:0]   rem_sh;
  logic [REM_W+1:0] trial;
  logic             fits;

  assign hold     = valid_r & dn_stall;
  assign up_stall = hold;

  // shift in next dividend bit, subtract divisor if it fits
  always_comb begin
    rem_sh        = {up_data.rem, up_data.dq[DVD_W-1]};
    trial         = {1'b0, rem_sh} - {2'b00, divisor};
    fits          = ~trial[REM_W+1];
    data_nxt.rem  = fits ? trial[REM_W-1:0] : rem_sh[REM_W-1:0];
    data_nxt.dq   = {up_data.dq[DVD_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!hold) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) data_r <= data_nxt;
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/rgbc_lux_calculator.sv
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_*_count          | sink
//  out     | out_valid, out_stall, out_lux_value     | source
//  cfg     | cfg_we, cfg_index, cfg_data             | sink
//
// One beat per cycle in and out while out is not stalled; the path is 3 front
// stages, 28 divider cells (one quotient bit each) and the output register.
// Reset is synchronous: empties the pipe and loads 12 ms, 1x (cpl 94).
// A stall on out holds each full stage back to the first bubble; bubbles are squeezed out.
// Depends on rlc_pkg, rlc_front, rlc_div_cell.
`default_nettype none

module rgbc_lux_calculator
  import rlc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SEL_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic [IN_W-1:0]      in_red_count,
  input  wire logic [IN_W-1:0]      in_green_count,
  input  wire logic [IN_W-1:0]      in_blue_count,
  input  wire logic [IN_W-1:0]      in_clear_count,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [LUX_W-1:0]     out_lux_value
);

  logic [SEL_W-1:0] itime_r, itime_nxt;
  logic [SEL_W-1:0] gain_r, gain_nxt;
  logic [CPL_W-1:0] cpl_r;

  logic             front_valid;
  logic [DVD_W-1:0] front_dividend;
  logic             front_stall;

  logic             cell_valid [DVD_W+1];
  rlc_div_t         cell_data  [DVD_W+1];
  logic             cell_stall [DVD_W+1];

  logic             out_valid_r;
  logic [LUX_W-1:0] lux_r, lux_nxt;
  logic             out_hold;
  logic [DVD_W-1:0] quot;

  // configuration registers, counts-per-lux follows every write
  always_comb begin
    itime_nxt = itime_r;
    gain_nxt  = gain_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_ITIME: itime_nxt = cfg_data;
        CFG_IDX_GAIN:  gain_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      itime_r <= ITIME_RST;
      gain_r  <= GAIN_RST;
      cpl_r   <= rlc_cpl(ITIME_RST, GAIN_RST);
    end else begin
      itime_r <= itime_nxt;
      gain_r  <= gain_nxt;
      cpl_r   <= rlc_cpl(itime_nxt, gain_nxt);
    end
  end

  // IR removal and weighted sum
  rlc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (in_valid),
    .up_stall    (in_stall),
    .red_count   (in_red_count),
    .green_count (in_green_count),
    .blue_count  (in_blue_count),
    .clear_count (in_clear_count),
    .dn_valid    (front_valid),
    .dn_dividend (front_dividend),
    .dn_stall    (front_stall)
  );

  // divider row head
  assign cell_valid[0]    = front_valid;
  assign cell_data[0].rem = '0;
  assign cell_data[0].dq  = front_dividend;
  assign front_stall      = cell_stall[0];

  for (genvar i = 0; i < DVD_W; i++) begin : g_cell
    rlc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .divisor  (cpl_r),
      .up_valid (cell_valid[i]),
      .up_data  (cell_data[i]),
      .up_stall (cell_stall[i]),
      .dn_valid (cell_valid[i+1]),
      .dn_data  (cell_data[i+1]),
      .dn_stall (cell_stall[i+1])
    );
  end

  // output register with saturation
  assign out_hold          = out_valid_r & out_stall;
  assign cell_stall[DVD_W] = out_hold;
  assign quot              = cell_data[DVD_W].dq;
  assign lux_nxt           = (|quot[DVD_W-1:LUX_W]) ? LUX_MAX : quot[LUX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_hold) begin
      out_valid_r <= cell_valid[DVD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_hold) lux_r <= lux_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_lux_value = lux_r;

`ifndef SYNTH
  // divisor always matches the stored selects
  a_cpl_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    cpl_r == rlc_cpl(itime_r, gain_r))
    else $error("counts_per_lux out of step with config");

  // back-pressure only originates at the output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without output stall");

  // a finished quotient reaches the output register
  a_last_cell_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid[DVD_W] && !out_hold) |=> out_valid_r)
    else $error("divider result dropped");

  // output drains when taken and nothing follows
  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !cell_valid[DVD_W]) |=> !out_valid_r)
    else $error("output beat repeated");
`endif

endmodule

`default_nettype wire
